@@ src/pressure_projection_solver_core_macros.svh @@
// assertion macros shared by the solver rtl
// expects clk_i and rst_ni in the scope of the using module
`ifndef PRESSURE_PROJECTION_SOLVER_CORE_MACROS_SVH
`define PRESSURE_PROJECTION_SOLVER_CORE_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pps_pkg.sv @@
// shared types, constants and helpers of the pressure projection solver
// no dependencies
package pps_pkg;

  // default sizes
  localparam int unsigned MAX_WIDTH_DEF     = 128;
  localparam int unsigned MAX_HEIGHT_DEF    = 128;
  localparam int unsigned FRACTION_BITS_DEF = 12;
  localparam int unsigned REL_FRAC          = 14;

  // field widths
  localparam int unsigned INDEX_W   = 14;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIM_W     = 8;
  localparam int unsigned SWEEP_W   = 10;
  localparam int unsigned RELAX_W   = 15;
  localparam int unsigned GAIN_W    = 31;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned CFG_ADDR_W = 5;

  // register reset values
  localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 8'd128;
  localparam logic [SWEEP_W-1:0] SWEEP_RST       = 10'd40;
  localparam logic [RELAX_W-1:0] RELAX_RST       = 15'd31130;
  localparam logic [GAIN_W-1:0]  DIV_GAIN_RST    = 31'd4096;
  localparam logic [GAIN_W-1:0]  GRAD_GAIN_RST   = 31'd4096;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_SWEEP_COUNT = 3'd2,
    REG_RELAX       = 3'd3,
    REG_DIV_GAIN    = 3'd4,
    REG_GRAD_GAIN   = 3'd5
  } reg_e;

  localparam logic RESULT_READ = 1'b0;
  localparam logic RESULT_DONE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   grid_width;
    logic [DIM_W-1:0]   grid_height;
    logic [SWEEP_W-1:0] sweep_count;
    logic [RELAX_W-1:0] relaxation_factor;
    logic [GAIN_W-1:0]  divergence_gain;
    logic [GAIN_W-1:0]  gradient_gain;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic read_item;
    logic load_read;
    logic load_done;
    logic clear_start;
    logic clear_step;
    logic pos_start;
    logic pos_next;
    logic fetch_start;
    logic fetch_step;
    logic rlx_sum;
    logic rlx_rhs;
    logic div_start;
    logic rlx_mul;
    logic rlx_write;
    logic grd_mul;
    logic grd_write;
    logic grd_zero;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic last_cell;
    logic fetch_done;
    logic cell_fluid;
    logic no_neighbor;
    logic div_done;
  } sts_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [71:0] x);
    if (x > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -72'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[WORD_W-1:0];
    end
  endfunction

endpackage

@@ src/pps_if.sv @@
// request and response channels of the solver
// depends on pps_pkg
interface pps_req_if import pps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_e                      op;
  logic [INDEX_W-1:0]       cell_index;
  logic                     fluid_flag;
  logic signed [WORD_W-1:0] horiz_velocity_in;
  logic signed [WORD_W-1:0] vert_velocity_in;

  modport source (output valid, op, cell_index, fluid_flag, horiz_velocity_in,
                  vert_velocity_in, input ready);
  modport sink (input valid, op, cell_index, fluid_flag, horiz_velocity_in,
                vert_velocity_in, output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic signed [WORD_W-1:0] pressure_out;
  logic signed [WORD_W-1:0] horiz_velocity_out;
  logic signed [WORD_W-1:0] vert_velocity_out;
  logic                     fluid_out;

  modport source (output valid, result_kind, pressure_out, horiz_velocity_out,
                  vert_velocity_out, fluid_out, input ready);
  modport sink (input valid, result_kind, pressure_out, horiz_velocity_out,
                vert_velocity_out, fluid_out, output ready);
endinterface

@@ src/pps_cfg.sv @@
// apb register file holding the solver configuration
// depends on pps_pkg
module pps_cfg import pps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GRID_WIDTH:  cfg_d.grid_width        = pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: cfg_d.grid_height       = pwdata[DIM_W-1:0];
        REG_SWEEP_COUNT: cfg_d.sweep_count       = pwdata[SWEEP_W-1:0];
        REG_RELAX:       cfg_d.relaxation_factor = pwdata[RELAX_W-1:0];
        REG_DIV_GAIN:    cfg_d.divergence_gain   = pwdata[GAIN_W-1:0];
        REG_GRAD_GAIN:   cfg_d.gradient_gain     = pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (idx)
      REG_GRID_WIDTH:  prdata = APB_W'(cfg_q.grid_width);
      REG_GRID_HEIGHT: prdata = APB_W'(cfg_q.grid_height);
      REG_SWEEP_COUNT: prdata = APB_W'(cfg_q.sweep_count);
      REG_RELAX:       prdata = APB_W'(cfg_q.relaxation_factor);
      REG_DIV_GAIN:    prdata = APB_W'(cfg_q.divergence_gain);
      REG_GRAD_GAIN:   prdata = APB_W'(cfg_q.gradient_gain);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width        <= GRID_WIDTH_RST;
      cfg_q.grid_height       <= GRID_HEIGHT_RST;
      cfg_q.sweep_count       <= SWEEP_RST;
      cfg_q.relaxation_factor <= RELAX_RST;
      cfg_q.divergence_gain   <= DIV_GAIN_RST;
      cfg_q.gradient_gain     <= GRAD_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/pps_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on pps_pkg
module pps_div import pps_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 33,
  parameter int unsigned DIVISOR_W  = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dsr_q;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // one restoring step
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift register holds dividend bits in and quotient bits out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dsr_q}) : DIVISOR_W'(trial);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ src/pps_datapath.sv @@
// grid memories, scan counters and fixed point arithmetic of the solver
// depends on pps_pkg and pps_div
module pps_datapath import pps_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [INDEX_W-1:0]       cell_index_i,
  input  logic                     fluid_flag_i,
  input  logic signed [WORD_W-1:0] horiz_velocity_i,
  input  logic signed [WORD_W-1:0] vert_velocity_i,
  output logic                     result_kind_o,
  output logic signed [WORD_W-1:0] pressure_o,
  output logic signed [WORD_W-1:0] horiz_velocity_o,
  output logic signed [WORD_W-1:0] vert_velocity_o,
  output logic                     fluid_o
);

  localparam int unsigned CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NB     = 5;
  // neighbor slots
  localparam int unsigned NB_C = 0;
  localparam int unsigned NB_L = 1;
  localparam int unsigned NB_R = 2;
  localparam int unsigned NB_B = 3;
  localparam int unsigned NB_T = 4;
  localparam logic [2:0]  PH_LAST = 3'd5;

  // memories
  logic                     s_mem [CELLS];
  logic signed [WORD_W-1:0] u_mem [CELLS];
  logic signed [WORD_W-1:0] v_mem [CELLS];
  logic signed [WORD_W-1:0] p_mem [CELLS];

  logic [ADDR_W-1:0] rd_addr, fetch_addr, idx_addr;
  logic              s_rd_q;
  logic signed [WORD_W-1:0] u_rd_q, v_rd_q, p_rd_q;
  logic              item_ok, item_ok_q, p_init_q;

  logic [COL_W-1:0]  w_eff, col_q;
  logic [ROW_W-1:0]  h_eff, row_q;
  logic [ADDR_W-1:0] w_ext, cell_q, clr_q;
  logic [2:0]        ph_q;

  logic                     s_q [NB];
  logic signed [WORD_W-1:0] u_q [NB];
  logic signed [WORD_W-1:0] v_q [NB];
  logic signed [WORD_W-1:0] p_q [NB];

  logic signed [34:0]       div_sum, psum_sum;
  logic [2:0]               n_cnt, n_q;
  logic signed [WORD_W-1:0] div_q, psum_q, rhs_q, pnew_q;
  logic signed [63:0]       rhs_prod;
  logic signed [33:0]       diff;
  logic [32:0]              mag, quo;
  logic                     sign_q, div_done;
  logic signed [71:0]       quo_s;
  logic signed [32:0]       dp;
  logic signed [48:0]       corr_prod;
  logic signed [48:0]       corr_q;
  logic signed [WORD_W-1:0] p_new;
  logic signed [32:0]       dl, db;
  logic signed [64:0]       gx_prod, gy_prod, gx_q, gy_q;
  logic signed [WORD_W-1:0] u_new, v_new;

  // clamped grid size
  always_comb begin
    if (cfg_i.grid_width < 8'd3) begin
      w_eff = COL_W'(3);
    end else if (32'(cfg_i.grid_width) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(cfg_i.grid_width);
    end
    if (cfg_i.grid_height < 8'd3) begin
      h_eff = ROW_W'(3);
    end else if (32'(cfg_i.grid_height) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(cfg_i.grid_height);
    end
  end
  assign w_ext = ADDR_W'(w_eff);

  assign idx_addr = ADDR_W'(cell_index_i);
  assign item_ok  = 32'(cell_index_i) < CELLS;

  // scan position, columns outer and rows inner
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_start) begin
      col_q  <= COL_W'(1);
      row_q  <= ROW_W'(1);
      cell_q <= w_ext + ADDR_W'(1);
    end else if (cmd_i.pos_next) begin
      if (row_q == h_eff - ROW_W'(2)) begin
        col_q  <= col_q + COL_W'(1);
        row_q  <= ROW_W'(1);
        cell_q <= w_ext + ADDR_W'(col_q) + ADDR_W'(1);
      end else begin
        row_q  <= row_q + ROW_W'(1);
        cell_q <= cell_q + w_ext;
      end
    end
  end

  // clear sweep counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_start) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // pressure reads as zero until the first clear has run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_init_q <= 1'b0;
    end else if (cmd_i.clear_step && clr_q == ADDR_W'(CELLS - 1)) begin
      p_init_q <= 1'b1;
    end
  end

  // fetch phase, one neighbor address per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else if (cmd_i.fetch_start) begin
      ph_q <= '0;
    end else if (cmd_i.fetch_step && ph_q != PH_LAST) begin
      ph_q <= ph_q + 3'd1;
    end
  end

  always_comb begin
    unique case (ph_q)
      3'd0:    fetch_addr = cell_q;
      3'd1:    fetch_addr = cell_q - ADDR_W'(1);
      3'd2:    fetch_addr = cell_q + ADDR_W'(1);
      3'd3:    fetch_addr = cell_q - w_ext;
      3'd4:    fetch_addr = cell_q + w_ext;
      default: fetch_addr = cell_q;
    endcase
  end

  assign rd_addr = cmd_i.read_item ? idx_addr : fetch_addr;

  // arithmetic of the update steps
  always_comb begin
    div_sum  = (s_q[NB_R] ? 35'(u_q[NB_R]) : 35'sd0) - (s_q[NB_L] ? 35'(u_q[NB_C]) : 35'sd0)
             + (s_q[NB_T] ? 35'(v_q[NB_T]) : 35'sd0) - (s_q[NB_B] ? 35'(v_q[NB_C]) : 35'sd0);
    psum_sum = (s_q[NB_L] ? 35'(p_q[NB_L]) : 35'sd0) + (s_q[NB_R] ? 35'(p_q[NB_R]) : 35'sd0)
             + (s_q[NB_B] ? 35'(p_q[NB_B]) : 35'sd0) + (s_q[NB_T] ? 35'(p_q[NB_T]) : 35'sd0);
    n_cnt    = 3'(s_q[NB_L]) + 3'(s_q[NB_R]) + 3'(s_q[NB_B]) + 3'(s_q[NB_T]);
    rhs_prod = $signed({1'b0, cfg_i.divergence_gain}) * div_q;
    diff     = 34'(psum_q) - 34'(rhs_q);
    mag      = diff[33] ? 33'(-diff) : 33'(diff);
    quo_s    = $signed({39'b0, quo});
    dp       = 33'(pnew_q) - 33'(p_q[NB_C]);
    corr_prod = $signed({1'b0, cfg_i.relaxation_factor}) * dp;
    p_new    = sat32(72'(p_q[NB_C]) + 72'(corr_q));
    dl       = 33'(p_q[NB_C]) - 33'(p_q[NB_L]);
    db       = 33'(p_q[NB_C]) - 33'(p_q[NB_B]);
    gx_prod  = $signed({1'b0, cfg_i.gradient_gain}) * dl;
    gy_prod  = $signed({1'b0, cfg_i.gradient_gain}) * db;
    u_new    = s_q[NB_L] ? sat32(72'(u_q[NB_C]) - 72'(gx_q)) : '0;
    v_new    = s_q[NB_B] ? sat32(72'(v_q[NB_C]) - 72'(gy_q)) : '0;
  end

  pps_div #(
    .DIVIDEND_W (33),
    .DIVISOR_W  (3)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // pipeline registers of the update steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_step && ph_q != 3'd0) begin
      s_q[ph_q - 3'd1] <= s_rd_q;
      u_q[ph_q - 3'd1] <= u_rd_q;
      v_q[ph_q - 3'd1] <= v_rd_q;
      p_q[ph_q - 3'd1] <= p_rd_q;
    end
    if (cmd_i.rlx_sum) begin
      div_q  <= sat32(72'(div_sum));
      psum_q <= sat32(72'(psum_sum));
      n_q    <= n_cnt;
    end
    if (cmd_i.rlx_rhs) begin
      rhs_q <= sat32(72'(rhs_prod >>> FRACTION_BITS));
    end
    if (cmd_i.div_start) begin
      sign_q <= diff[33];
    end
    if (div_done) begin
      pnew_q <= sat32(sign_q ? -quo_s : quo_s);
    end
    if (cmd_i.rlx_mul) begin
      corr_q <= corr_prod >>> REL_FRAC;
    end
    if (cmd_i.grd_mul) begin
      gx_q <= gx_prod >>> FRACTION_BITS;
      gy_q <= gy_prod >>> FRACTION_BITS;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item && item_ok) begin
      s_mem[idx_addr] <= fluid_flag_i;
    end
    s_rd_q <= s_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item && item_ok) begin
      u_mem[idx_addr] <= horiz_velocity_i;
    end else if (cmd_i.grd_write) begin
      u_mem[cell_q] <= u_new;
    end else if (cmd_i.grd_zero && !s_q[NB_R]) begin
      u_mem[cell_q + ADDR_W'(1)] <= '0;
    end
    u_rd_q <= u_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item && item_ok) begin
      v_mem[idx_addr] <= vert_velocity_i;
    end else if (cmd_i.grd_write) begin
      v_mem[cell_q] <= v_new;
    end else if (cmd_i.grd_zero && !s_q[NB_T]) begin
      v_mem[cell_q + w_ext] <= '0;
    end
    v_rd_q <= v_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      p_mem[clr_q] <= '0;
    end else if (cmd_i.rlx_write) begin
      p_mem[cell_q] <= p_new;
    end
    p_rd_q <= p_mem[rd_addr];
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_item) begin
      item_ok_q <= item_ok;
    end
    if (cmd_i.load_read) begin
      result_kind_o    <= RESULT_READ;
      pressure_o       <= (item_ok_q && p_init_q) ? p_rd_q : '0;
      horiz_velocity_o <= item_ok_q ? u_rd_q : '0;
      vert_velocity_o  <= item_ok_q ? v_rd_q : '0;
      fluid_o          <= item_ok_q && s_rd_q;
    end else if (cmd_i.load_done) begin
      result_kind_o    <= RESULT_DONE;
      pressure_o       <= '0;
      horiz_velocity_o <= '0;
      vert_velocity_o  <= '0;
      fluid_o          <= 1'b0;
    end
  end

  // status
  assign sts_o.clear_last  = clr_q == ADDR_W'(CELLS - 1);
  assign sts_o.last_cell   = (col_q == w_eff - COL_W'(2)) && (row_q == h_eff - ROW_W'(2));
  assign sts_o.fetch_done  = ph_q == PH_LAST;
  assign sts_o.cell_fluid  = s_q[NB_C];
  assign sts_o.no_neighbor = n_cnt == 3'd0;
  assign sts_o.div_done    = div_done;

endmodule

@@ src/pps_ctrl.sv @@
// controller state machine sequencing items, sweeps and cell steps
// depends on pps_pkg and the assertion macro header
`include "pressure_projection_solver_core_macros.svh"

module pps_ctrl import pps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SWEEP_W-1:0] sweep_count_i,
  input  logic               req_valid_i,
  input  op_e                req_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmd_t               cmd_o,
  input  sts_t               sts_i
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_READ     = 15'b000000000000010,
    S_CLEAR    = 15'b000000000000100,
    S_FETCH    = 15'b000000000001000,
    S_RLX_SUM  = 15'b000000000010000,
    S_RLX_RHS  = 15'b000000000100000,
    S_RLX_DST  = 15'b000000001000000,
    S_RLX_DIV  = 15'b000000010000000,
    S_RLX_MUL  = 15'b000000100000000,
    S_RLX_WR   = 15'b000001000000000,
    S_GRD_MUL  = 15'b000010000000000,
    S_GRD_WR   = 15'b000100000000000,
    S_GRD_ZERO = 15'b001000000000000,
    S_NEXT     = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_e;

  state_e             state_d, state_q;
  logic [SWEEP_W-1:0] sweep_d, sweep_q;
  logic               grad_d, grad_q;
  logic               out_valid_d, out_valid_q;
  logic               accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = req_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    grad_d      = grad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_op_i)
            OP_WRITE: cmd_o.load_item = 1'b1;
            OP_READ: begin
              cmd_o.read_item = 1'b1;
              state_d         = S_READ;
            end
            OP_SOLVE: begin
              cmd_o.clear_start = 1'b1;
              state_d           = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.load_read = 1'b1;
        out_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          cmd_o.pos_start   = 1'b1;
          cmd_o.fetch_start = 1'b1;
          sweep_d           = '0;
          grad_d            = sweep_count_i == '0;
          state_d           = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch_step = 1'b1;
        if (sts_i.fetch_done) begin
          state_d = grad_q ? S_GRD_MUL : S_RLX_SUM;
        end
      end
      S_RLX_SUM: begin
        cmd_o.rlx_sum = 1'b1;
        state_d = (!sts_i.cell_fluid || sts_i.no_neighbor) ? S_NEXT : S_RLX_RHS;
      end
      S_RLX_RHS: begin
        cmd_o.rlx_rhs = 1'b1;
        state_d       = S_RLX_DST;
      end
      S_RLX_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_RLX_DIV;
      end
      S_RLX_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_RLX_MUL;
        end
      end
      S_RLX_MUL: begin
        cmd_o.rlx_mul = 1'b1;
        state_d       = S_RLX_WR;
      end
      S_RLX_WR: begin
        cmd_o.rlx_write = 1'b1;
        state_d         = S_NEXT;
      end
      S_GRD_MUL: begin
        cmd_o.grd_mul = 1'b1;
        state_d       = sts_i.cell_fluid ? S_GRD_WR : S_NEXT;
      end
      S_GRD_WR: begin
        cmd_o.grd_write = 1'b1;
        state_d         = S_GRD_ZERO;
      end
      S_GRD_ZERO: begin
        cmd_o.grd_zero = 1'b1;
        state_d        = S_NEXT;
      end
      S_NEXT: begin
        if (!sts_i.last_cell) begin
          cmd_o.pos_next    = 1'b1;
          cmd_o.fetch_start = 1'b1;
          state_d           = S_FETCH;
        end else if (grad_q) begin
          state_d = S_DONE;
        end else begin
          // end of one sweep
          cmd_o.pos_start   = 1'b1;
          cmd_o.fetch_start = 1'b1;
          state_d           = S_FETCH;
          if ({1'b0, sweep_q} + 11'd1 == {1'b0, sweep_count_i}) begin
            grad_d = 1'b1;
          end else begin
            sweep_d = sweep_q + SWEEP_W'(1);
          end
        end
      end
      S_DONE: begin
        cmd_o.load_done = 1'b1;
        out_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sweep_q     <= '0;
      grad_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      grad_q      <= grad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // checks
  `PPS_ASSERT_NEXT(a_solve_clears, accept && (req_op_i == OP_SOLVE), state_q == S_CLEAR, "solve did not start with a clear")
  `PPS_ASSERT_IMPL(a_done_slot_free, state_q == S_DONE, !out_valid_q, "result slot busy at solve end")
  `PPS_ASSERT_IMPL(a_div_done_wait, sts_i.div_done, state_q == S_RLX_DIV, "divider finished outside its wait")
  `PPS_ASSERT_IMPL(a_busy_no_accept, in_ready_o, state_q == S_IDLE, "ready while busy")

endmodule

@@ src/pressure_projection_solver_core.sv @@
// top level of the pressure projection solver
// depends on pps_pkg, pps_if, pps_cfg, pps_ctrl, pps_datapath
//
// A write word loads one cell, a read word returns its cell through the memory read
// register and the result register, one item at a time. A solve word first clears all
// MAX_WIDTH*MAX_HEIGHT pressure entries, one per cycle, then walks the interior cells
// column by column for sweep_count sweeps: each cell fetches itself and its four neighbors
// in turn through the single read port of the grid memories; a solid cell or one with no
// fluid neighbor is skipped, and a relaxed fluid cell includes a bit-serial divide by the
// fluid neighbor count. A closing gradient pass over every interior cell follows, after
// which one solve-finished word is returned.
module pressure_projection_solver_core import pps_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pps_req_if.sink               req_i,
  pps_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  pps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  pps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sweep_count_i (cfg.sweep_count),
    .req_valid_i   (req_i.valid),
    .req_op_i      (req_i.op),
    .in_ready_o    (req_i.ready),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  // memories and arithmetic
  pps_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cell_index_i     (req_i.cell_index),
    .fluid_flag_i     (req_i.fluid_flag),
    .horiz_velocity_i (req_i.horiz_velocity_in),
    .vert_velocity_i  (req_i.vert_velocity_in),
    .result_kind_o    (rsp_o.result_kind),
    .pressure_o       (rsp_o.pressure_out),
    .horiz_velocity_o (rsp_o.horiz_velocity_out),
    .vert_velocity_o  (rsp_o.vert_velocity_out),
    .fluid_o          (rsp_o.fluid_out)
  );

endmodule
